>>> rtl/est_pkg.sv
// Shared widths, register indexes and state-mask constants for the ESC state tracker.
package est_pkg;

  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned SPEED_W  = 14;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_UPPER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_LOWER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_START_PULSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_START_PULSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT    = 3'd6;

  // Reset values of the configuration registers
  localparam pulse_t RST_FWD_THRESHOLD   = 16'd1490;
  localparam pulse_t RST_NEUTRAL_UPPER   = 16'd1510;
  localparam pulse_t RST_NEUTRAL_LOWER   = 16'd1446;
  localparam pulse_t RST_REV_THRESHOLD   = 16'd1466;
  localparam pulse_t RST_FWD_START_PULSE = 16'd1563;
  localparam pulse_t RST_REV_START_PULSE = 16'd1400;
  localparam cnt_t   RST_SETTLE_COUNT    = 8'd4;

  // Commands
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_ACTION  = 1'b1;

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_PASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd2;

  localparam logic [SPEED_W-1:0] SPEED_NEUTRAL = 14'd1500;

  // State mask: low nibble confirmed, high nibble pending; bit0 fwd, bit1 brake, bit2 back
  localparam mask_t MASK_RESET    = 8'h77;
  localparam mask_t MASK_HIGH     = 8'hF0;
  localparam mask_t MASK_P_FWD    = 8'h10;
  localparam mask_t MASK_P_BRAKE  = 8'h20;
  localparam mask_t MASK_P_FWD_BK = 8'h50;
  localparam mask_t MASK_P_BR_BK  = 8'h60;
  localparam mask_t MASK_ANY_FWD  = 8'h11;
  localparam mask_t MASK_ANY_BRK  = 8'h22;
  localparam mask_t MASK_ANY_BACK = 8'h44;

  localparam cnt_t CNT_ONE = 8'd1;

endpackage

>>> rtl/est_if.sv
// Valid/ready stream interfaces for the tracker's command and result channels.
interface est_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [est_pkg::PULSE_W-1:0]    observed_pulse;
  logic [est_pkg::SPEED_W-1:0]    speed_cmd;
  logic [est_pkg::MODE_W-1:0]     drive_mode;

  modport source (output valid, command, observed_pulse, speed_cmd, drive_mode,
                  input ready);
  modport sink   (input valid, command, observed_pulse, speed_cmd, drive_mode,
                  output ready);
  modport mon    (input valid, ready, command, observed_pulse, speed_cmd, drive_mode);
endinterface

interface est_out_if;
  logic                           valid;
  logic                           ready;
  logic [est_pkg::PULSE_W-1:0]    pulse_us;
  logic [est_pkg::NIBBLE_W-1:0]   confirmed_states;
  logic [est_pkg::NIBBLE_W-1:0]   pending_states;

  modport source (output valid, pulse_us, confirmed_states, pending_states, input ready);
  modport sink   (input valid, pulse_us, confirmed_states, pending_states, output ready);
  modport mon    (input valid, ready, pulse_us, confirmed_states, pending_states);
endinterface

>>> rtl/esc_state_tracker_unit.sv
// ESC state tracker: input register, state update / pulse selection, result register.
// Takes one transaction per clock cycle unless the result channel stalls; each
// result passes the input register, then the result register. The tracked state
// mask and settle counter are updated as a transaction leaves the input register,
// so the following transaction already sees them; a stalled result stage holds the
// input register, and the command channel stalls only when both are full.
module esc_state_tracker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [est_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [est_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  est_in_if.sink                              in_i,
  est_out_if.source                           out_o
);

  // configuration
  est_pkg::pulse_t fwd_thr_q, neu_up_q, neu_lo_q, rev_thr_q, fwd_start_q, rev_start_q;
  est_pkg::cnt_t   settle_q;

  // tracked state
  est_pkg::mask_t  mask_q, mask_d;
  est_pkg::cnt_t   cnt_q, cnt_d;

  // input register
  logic                          s1_vld_q;
  logic                          s1_cmd_q;
  est_pkg::pulse_t               s1_pulse_q;
  logic [est_pkg::SPEED_W-1:0]   s1_speed_q;
  logic [est_pkg::MODE_W-1:0]    s1_mode_q;

  // result register
  logic                          out_vld_q;
  est_pkg::pulse_t               out_pulse_q;
  logic [est_pkg::NIBBLE_W-1:0]  out_conf_q, out_pend_q;

  logic            in_acc, s1_adv;
  est_pkg::pulse_t pulse_res;
  est_pkg::mask_t  mask_res;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_thr_q   <= est_pkg::RST_FWD_THRESHOLD;
      neu_up_q    <= est_pkg::RST_NEUTRAL_UPPER;
      neu_lo_q    <= est_pkg::RST_NEUTRAL_LOWER;
      rev_thr_q   <= est_pkg::RST_REV_THRESHOLD;
      fwd_start_q <= est_pkg::RST_FWD_START_PULSE;
      rev_start_q <= est_pkg::RST_REV_START_PULSE;
      settle_q    <= est_pkg::RST_SETTLE_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        est_pkg::CFG_FWD_THRESHOLD:   fwd_thr_q   <= cfg_wdata_i;
        est_pkg::CFG_NEUTRAL_UPPER:   neu_up_q    <= cfg_wdata_i;
        est_pkg::CFG_NEUTRAL_LOWER:   neu_lo_q    <= cfg_wdata_i;
        est_pkg::CFG_REV_THRESHOLD:   rev_thr_q   <= cfg_wdata_i;
        est_pkg::CFG_FWD_START_PULSE: fwd_start_q <= cfg_wdata_i;
        est_pkg::CFG_REV_START_PULSE: rev_start_q <= cfg_wdata_i;
        est_pkg::CFG_SETTLE_COUNT:    settle_q    <= cfg_wdata_i[est_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state mask update for an observed pulse
  always_comb begin
    est_pkg::mask_t both;
    est_pkg::mask_t nxt;
    est_pkg::cnt_t  cnt_inc;
    both    = (mask_q | (mask_q << 4)) & est_pkg::MASK_HIGH;
    nxt     = {4'h0, mask_q[3:0]};
    cnt_inc = cnt_q + est_pkg::CNT_ONE;
    cnt_d   = cnt_q;
    if (s1_pulse_q >= fwd_thr_q) begin
      nxt = nxt | est_pkg::MASK_P_FWD;
    end
    if (s1_pulse_q <= neu_up_q && s1_pulse_q >= neu_lo_q) begin
      nxt = nxt | (both & est_pkg::MASK_P_FWD_BK) | ((both & est_pkg::MASK_P_BRAKE) << 1);
    end
    if (s1_pulse_q <= rev_thr_q) begin
      nxt = nxt | (both & est_pkg::MASK_P_BR_BK) | ((both & est_pkg::MASK_P_FWD) << 1);
    end
    if (nxt != mask_q) begin
      nxt   = {nxt[7:4], both[7:4]};
      cnt_d = est_pkg::CNT_ONE;
    end else if (cnt_inc >= settle_q) begin
      // pending set held long enough: confirm it, counter stays put
      nxt   = {nxt[7:4], nxt[7:4]};
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_inc;
    end
    mask_d = nxt;
  end

  // action pulse
  always_comb begin
    logic [est_pkg::PULSE_W:0]   thr_sum;
    est_pkg::pulse_t             neutral;
    est_pkg::pulse_t             delta;
    est_pkg::pulse_t             back;
    thr_sum = {1'b0, fwd_thr_q} + {1'b0, rev_thr_q};
    neutral = thr_sum[est_pkg::PULSE_W:1];
    delta   = {2'b00, s1_speed_q} - {2'b00, est_pkg::SPEED_NEUTRAL};
    back    = delta + rev_start_q;
    if (s1_speed_q == est_pkg::SPEED_NEUTRAL) begin
      pulse_res = neutral;
    end else if (s1_speed_q > est_pkg::SPEED_NEUTRAL) begin
      pulse_res = delta + fwd_start_q;
    end else if (s1_mode_q == est_pkg::MODE_PASS) begin
      pulse_res = back;
    end else if (s1_mode_q == est_pkg::MODE_BRAKE) begin
      pulse_res = ((mask_q & est_pkg::MASK_ANY_BACK) != '0) ? neu_up_q + 16'd1 : back;
    end else if ((mask_q & est_pkg::MASK_ANY_FWD) != '0) begin
      pulse_res = back;
    end else if ((mask_q & est_pkg::MASK_ANY_BRK) != '0) begin
      pulse_res = neutral;
    end else begin
      pulse_res = back;
    end
  end

  assign mask_res = (s1_cmd_q == est_pkg::CMD_OBSERVE) ? mask_d : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= est_pkg::MASK_RESET;
      cnt_q     <= est_pkg::CNT_ONE;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv && s1_cmd_q == est_pkg::CMD_OBSERVE) begin
        mask_q <= mask_d;
        cnt_q  <= cnt_d;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_i.command;
      s1_pulse_q <= in_i.observed_pulse;
      s1_speed_q <= in_i.speed_cmd;
      s1_mode_q  <= in_i.drive_mode;
    end
    if (s1_adv) begin
      out_pulse_q <= (s1_cmd_q == est_pkg::CMD_ACTION) ? pulse_res : '0;
      out_conf_q  <= mask_res[3:0];
      out_pend_q  <= mask_res[7:4];
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.pulse_us         = out_pulse_q;
  assign out_o.confirmed_states = out_conf_q;
  assign out_o.pending_states   = out_pend_q;

endmodule

>>> rtl/est_checker.sv
// Port-level assertions for the ESC state tracker, bound to the top level.
module est_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input est_pkg::pulse_t               out_pulse_i,
  input logic [est_pkg::NIBBLE_W-1:0]  out_conf_i,
  input logic [est_pkg::NIBBLE_W-1:0]  out_pend_i
);

  // command channel only stalls while a result is held back
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("command channel stalled without a held result");

  // no state encoding uses bit 3
  a_state_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!out_conf_i[3] && !out_pend_i[3]))
    else $error("state nibble has bit 3 set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_pulse_i) && $stable(out_conf_i)
       && $stable(out_pend_i)))
    else $error("stalled result transaction changed");

endmodule

bind esc_state_tracker_unit est_checker u_est_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pulse_i (out_o.pulse_us),
  .out_conf_i  (out_o.confirmed_states),
  .out_pend_i  (out_o.pending_states)
);

>>> tb/est_tracker_checker.sv
// Scoreboard for the ESC state tracker: predicts each result and checks the result channel.
`timescale 1ns / 1ps
module est_tracker_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [est_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [est_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  est_in_if.mon                          in_mon,
  est_out_if.mon                         out_mon,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    open_cnt_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [est_pkg::SPEED_W-1:0] speed_t;
  typedef logic [est_pkg::MODE_W-1:0]  mode_t;

  typedef struct packed {
    est_pkg::pulse_t                pulse;
    logic [est_pkg::NIBBLE_W-1:0]   confirmed;
    logic [est_pkg::NIBBLE_W-1:0]   pending;
  } track_res_t;

  est_pkg::pulse_t thr_fwd, neu_hi, neu_lo, thr_rev, start_fwd, start_rev;
  est_pkg::cnt_t   settle_lim;
  est_pkg::mask_t  trk_mask;
  est_pkg::cnt_t   settle_cnt;

  track_res_t  res_q[$];
  int unsigned fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  function automatic void observe_pulse(est_pkg::pulse_t p);
    est_pkg::mask_t cur, nxt, both;
    cur  = trk_mask;
    nxt  = {4'h0, cur[3:0]};
    both = {cur[7:4] | cur[3:0], 4'h0};
    if (p >= thr_fwd)
      nxt |= est_pkg::MASK_P_FWD;
    if (p <= neu_hi && p >= neu_lo)
      nxt |= (both & est_pkg::MASK_P_FWD_BK) | ((both & est_pkg::MASK_P_BRAKE) << 1);
    if (p <= thr_rev)
      nxt |= (both & est_pkg::MASK_P_BR_BK) | ((both & est_pkg::MASK_P_FWD) << 1);
    if (nxt != cur) begin
      nxt = (nxt & est_pkg::MASK_HIGH) | (both >> 4);
      settle_cnt = est_pkg::CNT_ONE;
    end else begin
      settle_cnt = settle_cnt + est_pkg::CNT_ONE;
      // pending set has held long enough: it replaces the confirmed set
      if (settle_cnt >= settle_lim) begin
        nxt = (nxt & est_pkg::MASK_HIGH) | (nxt >> 4);
        settle_cnt = settle_cnt - est_pkg::CNT_ONE;
      end
    end
    trk_mask = nxt;
  endfunction

  function automatic est_pkg::pulse_t action_pulse(speed_t speed, mode_t mode);
    logic [est_pkg::PULSE_W:0] sum;
    est_pkg::pulse_t neutral, back;
    sum     = {1'b0, thr_fwd} + {1'b0, thr_rev};
    neutral = sum[est_pkg::PULSE_W:1];
    back    = est_pkg::pulse_t'(speed) - est_pkg::pulse_t'(est_pkg::SPEED_NEUTRAL)
              + start_rev;
    if (speed == est_pkg::SPEED_NEUTRAL)
      return neutral;
    if (speed > est_pkg::SPEED_NEUTRAL)
      return est_pkg::pulse_t'(speed) - est_pkg::pulse_t'(est_pkg::SPEED_NEUTRAL)
             + start_fwd;
    if (mode == est_pkg::MODE_PASS)
      return back;
    if (mode == est_pkg::MODE_BRAKE)
      return ((trk_mask & est_pkg::MASK_ANY_BACK) != '0) ?
             est_pkg::pulse_t'(neu_hi + 16'd1) : back;
    if ((trk_mask & est_pkg::MASK_ANY_FWD) != '0)
      return back;
    if ((trk_mask & est_pkg::MASK_ANY_BRK) != '0)
      return neutral;
    return back;
  endfunction

  function automatic track_res_t predict_result(logic cmd, est_pkg::pulse_t p,
                                                speed_t speed, mode_t mode);
    track_res_t r;
    r.pulse = '0;
    if (cmd == est_pkg::CMD_OBSERVE)
      observe_pulse(p);
    else
      r.pulse = action_pulse(speed, mode);
    r.confirmed = trk_mask[3:0];
    r.pending   = trk_mask[7:4];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_sb
    track_res_t got, want;
    if (!rst_ni) begin
      thr_fwd    = est_pkg::RST_FWD_THRESHOLD;
      neu_hi     = est_pkg::RST_NEUTRAL_UPPER;
      neu_lo     = est_pkg::RST_NEUTRAL_LOWER;
      thr_rev    = est_pkg::RST_REV_THRESHOLD;
      start_fwd  = est_pkg::RST_FWD_START_PULSE;
      start_rev  = est_pkg::RST_REV_START_PULSE;
      settle_lim = est_pkg::RST_SETTLE_COUNT;
      trk_mask   = est_pkg::MASK_RESET;
      settle_cnt = est_pkg::CNT_ONE;
      res_q.delete();
      open_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          est_pkg::CFG_FWD_THRESHOLD:   thr_fwd    = cfg_wdata_i;
          est_pkg::CFG_NEUTRAL_UPPER:   neu_hi     = cfg_wdata_i;
          est_pkg::CFG_NEUTRAL_LOWER:   neu_lo     = cfg_wdata_i;
          est_pkg::CFG_REV_THRESHOLD:   thr_rev    = cfg_wdata_i;
          est_pkg::CFG_FWD_START_PULSE: start_fwd  = cfg_wdata_i;
          est_pkg::CFG_REV_START_PULSE: start_rev  = cfg_wdata_i;
          est_pkg::CFG_SETTLE_COUNT:    settle_lim = cfg_wdata_i[est_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.pulse     = out_mon.pulse_us;
        got.confirmed = out_mon.confirmed_states;
        got.pending   = out_mon.pending_states;
        if (res_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result transaction: pulse %0d confirmed %h pending %h",
                     $time, got.pulse, got.confirmed, got.pending);
        end else begin
          want = res_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("%0t: mismatch: pulse exp %0d got %0d, %s %h got %h, %s %h got %h",
                       $time, want.pulse, got.pulse, "confirmed exp", want.confirmed,
                       got.confirmed, "pending exp", want.pending, got.pending);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        res_q.push_back(predict_result(in_mon.command, in_mon.observed_pulse,
                                       in_mon.speed_cmd, in_mon.drive_mode));
      open_cnt_o <= res_q.size();
    end
  end

endmodule

>>> tb/tb_esc_state_tracker_unit.sv
// Testbench top for the ESC state tracker: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_esc_state_tracker_unit;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 10;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 200;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int PRESS_PHASE = 3;
  localparam int NUM_CFG     = 7;
  localparam int MAX_BURST   = 300;
  localparam int TAIL_CYCLES = 8;

  typedef logic [est_pkg::SPEED_W-1:0]    speed_t;
  typedef logic [est_pkg::MODE_W-1:0]     mode_t;
  typedef logic [est_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [est_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam mode_t MODE_BACK    = 2'd1;
  localparam mode_t MODE_BACK_HI = 2'd3;

  typedef enum int {REG_FWD, REG_NEUTRAL, REG_REV, REG_ANY} pulse_region_e;
  typedef enum int {CFG_ALL_ZERO, CFG_ALL_MAX, CFG_DEFAULT_FAST, CFG_NEAR_NEUTRAL,
                    CFG_DEAD_BAND, CFG_WILD} cfg_style_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_word_t cfg_wdata;

  est_in_if  in_bus ();
  est_out_if out_bus ();

  int unsigned fail_cnt, open_cnt;
  cfg_word_t cur_cfg [NUM_CFG];
  bit tx_idle_on = 1'b1;
  bit stall_req;
  bit stall_done = 1'b0;
  int obs_cnt = 0, act_cnt = 0, cfg_sets = 0, idle_cycles = 0;

  esc_state_tracker_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  est_tracker_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_cnt_o (fail_cnt),
    .open_cnt_o (open_cnt)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic est_pkg::pulse_t rand_between(int unsigned a, int unsigned b);
    if (a > b) return est_pkg::pulse_t'($urandom_range(b, a));
    return est_pkg::pulse_t'($urandom_range(a, b));
  endfunction

  function automatic est_pkg::pulse_t pulse_in(pulse_region_e region);
    case (region)
      REG_FWD:     return rand_between(cur_cfg[est_pkg::CFG_FWD_THRESHOLD], 16'hFFFF);
      REG_NEUTRAL: return rand_between(cur_cfg[est_pkg::CFG_NEUTRAL_LOWER],
                                       cur_cfg[est_pkg::CFG_NEUTRAL_UPPER]);
      REG_REV:     return rand_between(0, cur_cfg[est_pkg::CFG_REV_THRESHOLD]);
      default:     return est_pkg::pulse_t'($urandom);
    endcase
  endfunction

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : result_sink
    int n, iter;
    bit rx_quiet;
    out_bus.ready <= 1'b0;
    rx_quiet = 1'b0;
    iter = 0;
    forever begin
      if (stall_req && !stall_done) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        stall_done = 1'b1;
      end
      if (iter % 64 == 0)
        rx_quiet = ($urandom_range(0, 3) == 0);
      iter++;
      n = rx_quiet ? 0 : pick_gap();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic cmd, est_pkg::pulse_t pulse, speed_t speed, mode_t mode);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.command        <= cmd;
    in_bus.observed_pulse <= pulse;
    in_bus.speed_cmd      <= speed;
    in_bus.drive_mode     <= mode;
    do @(posedge clk_i); while (!in_bus.ready);
    if (cmd == est_pkg::CMD_OBSERVE) obs_cnt++;
    else act_cnt++;
  endtask

  task automatic send_observe(est_pkg::pulse_t pulse);
    send_item(est_pkg::CMD_OBSERVE, pulse, speed_t'($urandom), mode_t'($urandom));
  endtask

  task automatic send_action(speed_t speed, mode_t mode);
    send_item(est_pkg::CMD_ACTION, est_pkg::pulse_t'($urandom), speed, mode);
  endtask

  task automatic send_random_action();
    speed_t speed;
    case ($urandom_range(0, 3))
      0:       speed = est_pkg::SPEED_NEUTRAL;
      1:       speed = speed_t'($urandom);
      2:       speed = speed_t'($urandom_range(1400, 1600));
      default: speed = speed_t'($urandom_range(0, 1499));
    endcase
    send_action(speed, mode_t'($urandom));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (open_cnt != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config();
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_t'(i);
      cfg_wdata <= (i == est_pkg::CFG_SETTLE_COUNT) ? {8'($urandom), cur_cfg[i][7:0]}
                                                    : cur_cfg[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  task automatic pick_config(cfg_style_e style);
    case (style)
      CFG_ALL_ZERO: begin
        foreach (cur_cfg[i]) cur_cfg[i] = '0;
      end
      CFG_ALL_MAX: begin
        foreach (cur_cfg[i]) cur_cfg[i] = 16'hFFFF;
        cur_cfg[est_pkg::CFG_SETTLE_COUNT] = 16'h00FF;
      end
      CFG_DEFAULT_FAST: begin
        cur_cfg[est_pkg::CFG_FWD_THRESHOLD]   = est_pkg::RST_FWD_THRESHOLD;
        cur_cfg[est_pkg::CFG_NEUTRAL_UPPER]   = est_pkg::RST_NEUTRAL_UPPER;
        cur_cfg[est_pkg::CFG_NEUTRAL_LOWER]   = est_pkg::RST_NEUTRAL_LOWER;
        cur_cfg[est_pkg::CFG_REV_THRESHOLD]   = est_pkg::RST_REV_THRESHOLD;
        cur_cfg[est_pkg::CFG_FWD_START_PULSE] = est_pkg::RST_FWD_START_PULSE;
        cur_cfg[est_pkg::CFG_REV_START_PULSE] = est_pkg::RST_REV_START_PULSE;
        cur_cfg[est_pkg::CFG_SETTLE_COUNT]    = 16'd1;
      end
      CFG_NEAR_NEUTRAL: begin
        cur_cfg[est_pkg::CFG_FWD_THRESHOLD]   = cfg_word_t'($urandom_range(1450, 1550));
        cur_cfg[est_pkg::CFG_NEUTRAL_UPPER]   = cfg_word_t'($urandom_range(1480, 1600));
        cur_cfg[est_pkg::CFG_NEUTRAL_LOWER]   = cfg_word_t'($urandom_range(1380, 1480));
        cur_cfg[est_pkg::CFG_REV_THRESHOLD]   = cfg_word_t'($urandom_range(1400, 1500));
        cur_cfg[est_pkg::CFG_FWD_START_PULSE] = cfg_word_t'($urandom_range(1500, 1700));
        cur_cfg[est_pkg::CFG_REV_START_PULSE] = cfg_word_t'($urandom_range(1300, 1480));
        cur_cfg[est_pkg::CFG_SETTLE_COUNT]    = cfg_word_t'($urandom_range(1, 8));
      end
      CFG_DEAD_BAND: begin
        // empty neutral window and a gap between the forward and reverse classes
        cur_cfg[est_pkg::CFG_FWD_THRESHOLD]   = cfg_word_t'($urandom_range(1600, 1700));
        cur_cfg[est_pkg::CFG_NEUTRAL_UPPER]   = cfg_word_t'($urandom_range(1450, 1500));
        cur_cfg[est_pkg::CFG_NEUTRAL_LOWER]   = cfg_word_t'($urandom_range(1501, 1550));
        cur_cfg[est_pkg::CFG_REV_THRESHOLD]   = cfg_word_t'($urandom_range(1300, 1400));
        cur_cfg[est_pkg::CFG_FWD_START_PULSE] = cfg_word_t'($urandom_range(1500, 1700));
        cur_cfg[est_pkg::CFG_REV_START_PULSE] = cfg_word_t'($urandom_range(1300, 1480));
        cur_cfg[est_pkg::CFG_SETTLE_COUNT]    = cfg_word_t'($urandom_range(0, 3));
      end
      default: begin
        foreach (cur_cfg[i]) cur_cfg[i] = cfg_word_t'($urandom);
        cur_cfg[est_pkg::CFG_SETTLE_COUNT] = cfg_word_t'($urandom_range(0, 20));
      end
    endcase
  endtask

  initial begin : stimulus
    int n, len;
    pulse_region_e region;
    cfg_style_e style;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    stall_req             <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.command        <= est_pkg::CMD_OBSERVE;
    in_bus.observed_pulse <= '0;
    in_bus.speed_cmd      <= '0;
    in_bus.drive_mode     <= est_pkg::MODE_PASS;
    foreach (cur_cfg[i]) cur_cfg[i] = '0;
    cur_cfg[est_pkg::CFG_FWD_THRESHOLD] = est_pkg::RST_FWD_THRESHOLD;
    cur_cfg[est_pkg::CFG_NEUTRAL_UPPER] = est_pkg::RST_NEUTRAL_UPPER;
    cur_cfg[est_pkg::CFG_NEUTRAL_LOWER] = est_pkg::RST_NEUTRAL_LOWER;
    cur_cfg[est_pkg::CFG_REV_THRESHOLD] = est_pkg::RST_REV_THRESHOLD;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, all states possible
    send_action(est_pkg::SPEED_NEUTRAL, est_pkg::MODE_PASS);
    send_action(14'h3FFF, est_pkg::MODE_PASS);
    send_action(14'd0, est_pkg::MODE_PASS);
    send_action(14'd1499, est_pkg::MODE_BRAKE);
    send_action(14'd1000, MODE_BACK);
    repeat (5) send_observe(16'hFFFF);
    repeat (5) send_observe(16'd0);
    // brake only: backward mode sends neutral, brake mode falls back
    send_action(14'd1200, MODE_BACK_HI);
    send_action(14'd1200, est_pkg::MODE_BRAKE);
    send_observe(16'd1480);
    repeat (4) send_observe(est_pkg::RST_REV_THRESHOLD);
    send_action(14'd1300, est_pkg::MODE_BRAKE);
    send_observe(est_pkg::RST_FWD_THRESHOLD);
    send_observe(est_pkg::RST_NEUTRAL_UPPER);
    send_observe(est_pkg::RST_NEUTRAL_LOWER);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      style = (ph < 2) ? cfg_style_e'(ph) : cfg_style_e'(2 + (ph - 2) % 4);
      pick_config(style);
      load_config();
      tx_idle_on = (ph == PRESS_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == PRESS_PHASE)
        stall_req <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // run of pulses from one region (or fully random), up to settle count + 2 long, with action reads mixed in
          region = pulse_region_e'($urandom_range(0, 3));
          len = $urandom_range(1, cur_cfg[est_pkg::CFG_SETTLE_COUNT][7:0] + 2);
          if (len > MAX_BURST) len = MAX_BURST;
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0) begin
              send_random_action();
              n++;
            end
            send_observe(pulse_in(region));
            n++;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          send_random_action();
          n++;
        end else begin
          send_item(1'($urandom), est_pkg::pulse_t'($urandom), speed_t'($urandom),
                    mode_t'($urandom));
          n++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d observe and %0d action transactions over %0d register settings,",
             obs_cnt, act_cnt, cfg_sets);
    $display("with random gaps on both channels and a %0d-cycle result hold-off.", LONG_HOLD);
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d results missing", fail_cnt, open_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
